// File: design/fcrd_pkg.sv
// Shared types, constants and codes of the front-coded record deframer.
// No dependencies; every other file of the block but fcrd_req_if refers to this package.
package fcrd_pkg;

   localparam int WORD_BUFFER_BYTES = 1024;
   localparam int POSITION_BITS     = 24;
   localparam int WORD_INDEX_BITS   = $clog2(WORD_BUFFER_BYTES + 1);
   localparam int MAX_RESULTS       = 3;
   localparam int COUNT_BITS        = $clog2(MAX_RESULTS + 1);
   localparam int SLOT_BITS         = $clog2(MAX_RESULTS);
   localparam int PAYLOAD_BITS      = 31;
   localparam int FIELD_BITS        = 32;
   localparam int SEEN_BITS         = 3;
   localparam int CSR_ADDR_BITS     = 3;
   localparam int CSR_DATA_BITS     = 32;

   localparam logic [15:0] BLOCK_SIZE_RESET = 16'd1024;
   localparam logic [15:0] HDR_FOUR_BYTE    = 16'h8000;
   localparam logic [15:0] HDR_COUNT_MASK   = 16'h7fff;

   localparam logic [SEEN_BITS-1:0] LEN_BYTES_SHORT = SEEN_BITS'(2);
   localparam logic [SEEN_BITS-1:0] LEN_BYTES_LONG  = SEEN_BITS'(4);

   localparam logic [7:0] ERR_NEGATIVE_LENGTH = 8'd0;
   localparam logic [7:0] ERR_WORD_OVERFLOW   = 8'd1;

   // register index, taken from paddr[2]
   localparam logic CSR_ALIGNED_LAYOUT = 1'b0;
   localparam logic CSR_BLOCK_SIZE     = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR_HI,
      PH_LEN,
      PH_PREFIX,
      PH_ATTR_FIRST,
      PH_WORD,
      PH_ATTR_AFTER,
      PH_DATA
   } phase_type;

   typedef enum logic [2:0] {
      K_PREFIX,
      K_WORD,
      K_WORD_END,
      K_ATTR,
      K_DATA,
      K_REC_END,
      K_BLK_END,
      K_ERROR
   } kind_type;

   typedef struct packed {
      logic        aligned_layout;
      logic [15:0] block_size;
   } cfg_type;

   typedef struct packed {
      kind_type                 kind;
      logic [7:0]               value;
      logic [POSITION_BITS-1:0] position;
   } result_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]              count;
      result_type [MAX_RESULTS-1:0]       res;
   } bundle_type;

endpackage

// File: design/fcrd_req_if.sv
// Input channel of the deframer: one stream byte and its block start flag.
// Depends on nothing.
interface fcrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       block_start;

   modport source (output valid, data_byte, block_start, input ready);
   modport sink   (input valid, data_byte, block_start, output ready);
endinterface

// File: design/fcrd_rsp_if.sv
// Result channel of the deframer: one tagged result per transaction.
// Depends on fcrd_pkg for the kind type and position width.
interface fcrd_rsp_if;
   logic                              valid;
   logic                              ready;
   fcrd_pkg::kind_type                kind;
   logic [7:0]                        value;
   logic [fcrd_pkg::POSITION_BITS-1:0] position;
   logic                              last;

   modport source (output valid, kind, value, position, last, input ready);
   modport sink   (input valid, kind, value, position, last, output ready);
endinterface

// File: design/fcrd_csr.sv
// Configuration registers of the deframer behind an APB-style port.
// Depends on fcrd_pkg.
module fcrd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [fcrd_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [fcrd_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [fcrd_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready,
   output fcrd_pkg::cfg_type                  cfg
);

   fcrd_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         if (csr_paddr[2] == fcrd_pkg::CSR_BLOCK_SIZE) begin
            cfg_in.block_size = csr_pwdata[15:0];
         end else begin
            cfg_in.aligned_layout = csr_pwdata[0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == fcrd_pkg::CSR_BLOCK_SIZE) begin
         csr_prdata = fcrd_pkg::CSR_DATA_BITS'(cfg_ff.block_size);
      end else begin
         csr_prdata = fcrd_pkg::CSR_DATA_BITS'(cfg_ff.aligned_layout);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.aligned_layout <= 1'b0;
         cfg_ff.block_size     <= fcrd_pkg::BLOCK_SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/fcrd_parser.sv
// Input register and record parser: turns one stream byte into a bundle of up
// to three tagged results. Depends on fcrd_pkg and fcrd_req_if.
module fcrd_parser (
   input  logic                  clock,
   input  logic                  reset,
   fcrd_req_if.sink              req_bus,
   input  fcrd_pkg::cfg_type     cfg,
   input  logic                  bundle_free,
   output logic                  bundle_load,
   output fcrd_pkg::bundle_type  bundle
);

   localparam int PB = fcrd_pkg::POSITION_BITS;
   localparam int WB = fcrd_pkg::WORD_INDEX_BITS;

   logic                                  in_valid_ff, in_valid_in;
   logic [7:0]                            in_byte_ff;
   logic                                  in_start_ff;
   logic                                  fire;

   fcrd_pkg::phase_type                   phase_ff, phase_in;
   logic                                  four_ff, four_in;
   logic [fcrd_pkg::PAYLOAD_BITS-1:0]     payload_ff, payload_in;
   logic [fcrd_pkg::SEEN_BITS-1:0]        seen_ff, seen_in;
   logic [fcrd_pkg::FIELD_BITS-1:0]       field_ff, field_in;
   logic [WB-1:0]                         widx_ff, widx_in;
   logic [PB-1:0]                         didx_ff, didx_in;
   logic [PB-1:0]                         offset_ff, offset_in;

   fcrd_pkg::result_type [fcrd_pkg::MAX_RESULTS-1:0] res;
   logic [fcrd_pkg::COUNT_BITS-1:0]       n;
   logic                                  rec_end;
   logic                                  after_fixed;
   logic [15:0]                           hdr;
   logic [fcrd_pkg::PAYLOAD_BITS-1:0]     total;
   logic [fcrd_pkg::FIELD_BITS-1:0]       field_new;
   logic [fcrd_pkg::SEEN_BITS-1:0]        need;
   logic                                  sign;

   assign fire          = in_valid_ff && bundle_free;
   assign req_bus.ready = !in_valid_ff || fire;
   assign in_valid_in   = req_bus.valid || (in_valid_ff && !fire);

   assign hdr       = {req_bus.data_byte & 8'h00 | in_byte_ff, payload_ff[7:0]};
   assign total     = fcrd_pkg::PAYLOAD_BITS'(cfg.block_size)
                      * fcrd_pkg::PAYLOAD_BITS'(hdr & fcrd_pkg::HDR_COUNT_MASK);
   assign field_new = field_ff
                      | (fcrd_pkg::FIELD_BITS'(in_byte_ff) << {seen_ff[1:0], 3'b000});
   assign need      = four_ff ? fcrd_pkg::LEN_BYTES_LONG : fcrd_pkg::LEN_BYTES_SHORT;
   assign sign      = four_ff ? field_new[fcrd_pkg::FIELD_BITS-1] : field_new[15];

   // next state and result bundle
   always_comb begin
      phase_in    = phase_ff;
      four_in     = four_ff;
      payload_in  = payload_ff;
      seen_in     = seen_ff;
      field_in    = field_ff;
      widx_in     = widx_ff;
      didx_in     = didx_ff;
      offset_in   = offset_ff;
      n           = '0;
      rec_end     = 1'b0;
      after_fixed = 1'b0;
      for (int i = 0; i < fcrd_pkg::MAX_RESULTS; i++) begin
         res[i] = '{kind: fcrd_pkg::K_PREFIX, value: 8'd0, position: '0};
      end

      if (fire) begin
         offset_in = offset_ff + 1'b1;
         if (in_start_ff) begin
            // low header byte parks in the payload counter
            payload_in = fcrd_pkg::PAYLOAD_BITS'(in_byte_ff);
            phase_in   = fcrd_pkg::PH_HDR_HI;
         end else if (phase_ff != fcrd_pkg::PH_IDLE) begin
            if (phase_ff != fcrd_pkg::PH_HDR_HI && payload_ff != '0) begin
               payload_in = payload_ff - 1'b1;
            end
            if ((phase_ff == fcrd_pkg::PH_WORD || phase_ff == fcrd_pkg::PH_ATTR_AFTER ||
                 phase_ff == fcrd_pkg::PH_DATA) && field_ff != '0) begin
               field_in = field_ff - 1'b1;
            end

            case (phase_ff)
               fcrd_pkg::PH_HDR_HI: begin
                  four_in = |(hdr & fcrd_pkg::HDR_FOUR_BYTE);
                  if (total <= fcrd_pkg::PAYLOAD_BITS'(2)) begin
                     payload_in = '0;
                     res[n] = '{kind: fcrd_pkg::K_BLK_END, value: 8'd0, position: '0};
                     n = n + 1'b1;
                     phase_in = fcrd_pkg::PH_IDLE;
                  end else begin
                     payload_in = total - fcrd_pkg::PAYLOAD_BITS'(2);
                     field_in   = '0;
                     seen_in    = '0;
                     phase_in   = fcrd_pkg::PH_LEN;
                  end
               end
               fcrd_pkg::PH_LEN: begin
                  field_in = field_new;
                  seen_in  = seen_ff + 1'b1;
                  if (seen_in >= need) begin
                     if (sign) begin
                        res[n] = '{kind: fcrd_pkg::K_ERROR,
                                   value: fcrd_pkg::ERR_NEGATIVE_LENGTH,
                                   position: offset_ff};
                        n = n + 1'b1;
                        phase_in = fcrd_pkg::PH_IDLE;
                     end else if (!four_ff && field_new == '0) begin
                        res[n] = '{kind: fcrd_pkg::K_BLK_END, value: 8'd0, position: '0};
                        n = n + 1'b1;
                        phase_in = fcrd_pkg::PH_IDLE;
                     end else begin
                        phase_in = fcrd_pkg::PH_PREFIX;
                     end
                  end
               end
               fcrd_pkg::PH_PREFIX: begin
                  widx_in = WB'(in_byte_ff);
                  didx_in = '0;
                  res[n] = '{kind: fcrd_pkg::K_PREFIX, value: in_byte_ff,
                             position: offset_ff};
                  n = n + 1'b1;
                  phase_in = cfg.aligned_layout ? fcrd_pkg::PH_ATTR_FIRST
                                                : fcrd_pkg::PH_WORD;
               end
               fcrd_pkg::PH_ATTR_FIRST: begin
                  res[n] = '{kind: fcrd_pkg::K_ATTR, value: in_byte_ff, position: '0};
                  n = n + 1'b1;
                  phase_in = fcrd_pkg::PH_WORD;
               end
               fcrd_pkg::PH_WORD: begin
                  if (in_byte_ff != 8'd0) begin
                     if (widx_ff >= WB'(fcrd_pkg::WORD_BUFFER_BYTES)) begin
                        // saturate at the last buffer slot and flag it
                        res[n] = '{kind: fcrd_pkg::K_WORD, value: in_byte_ff,
                                   position: PB'(fcrd_pkg::WORD_BUFFER_BYTES - 1)};
                        n = n + 1'b1;
                        res[n] = '{kind: fcrd_pkg::K_ERROR,
                                   value: fcrd_pkg::ERR_WORD_OVERFLOW,
                                   position: PB'(fcrd_pkg::WORD_BUFFER_BYTES - 1)};
                        n = n + 1'b1;
                     end else begin
                        res[n] = '{kind: fcrd_pkg::K_WORD, value: in_byte_ff,
                                   position: PB'(widx_ff)};
                        n = n + 1'b1;
                        widx_in = widx_ff + 1'b1;
                     end
                  end else begin
                     res[n] = '{kind: fcrd_pkg::K_WORD_END, value: 8'd0,
                                position: PB'(widx_ff)};
                     n = n + 1'b1;
                     if (cfg.aligned_layout) begin
                        after_fixed = 1'b1;
                     end else begin
                        phase_in = fcrd_pkg::PH_ATTR_AFTER;
                     end
                  end
               end
               fcrd_pkg::PH_ATTR_AFTER: begin
                  res[n] = '{kind: fcrd_pkg::K_ATTR, value: in_byte_ff, position: '0};
                  n = n + 1'b1;
                  after_fixed = 1'b1;
               end
               fcrd_pkg::PH_DATA: begin
                  res[n] = '{kind: fcrd_pkg::K_DATA, value: in_byte_ff, position: didx_ff};
                  n = n + 1'b1;
                  didx_in = didx_ff + 1'b1;
                  rec_end = (field_in == '0);
               end
               default: begin
                  phase_in = fcrd_pkg::PH_IDLE;
               end
            endcase

            if (after_fixed) begin
               if (field_in == '0) begin
                  rec_end = 1'b1;
               end else begin
                  phase_in = fcrd_pkg::PH_DATA;
               end
            end

            if (rec_end) begin
               res[n] = '{kind: fcrd_pkg::K_REC_END, value: 8'd0, position: didx_in};
               n = n + 1'b1;
               if (four_ff || payload_in == '0) begin
                  res[n] = '{kind: fcrd_pkg::K_BLK_END, value: 8'd0, position: '0};
                  n = n + 1'b1;
                  phase_in = fcrd_pkg::PH_IDLE;
               end else begin
                  field_in = '0;
                  seen_in  = '0;
                  phase_in = fcrd_pkg::PH_LEN;
               end
            end
         end
      end
   end

   assign bundle_load  = fire && (n != '0);
   assign bundle.count = n;
   assign bundle.res   = res;

   always_ff @(posedge clock) begin
      if (req_bus.ready) begin
         in_byte_ff  <= req_bus.data_byte;
         in_start_ff <= req_bus.block_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= fcrd_pkg::PH_IDLE;
         four_ff     <= 1'b0;
         payload_ff  <= '0;
         seen_ff     <= '0;
         field_ff    <= '0;
         widx_ff     <= '0;
         didx_ff     <= '0;
         offset_ff   <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         four_ff     <= four_in;
         payload_ff  <= payload_in;
         seen_ff     <= seen_in;
         field_ff    <= field_in;
         widx_ff     <= widx_in;
         didx_ff     <= didx_in;
         offset_ff   <= offset_in;
      end
   end

   // headword index never runs past the buffer size
   assert property (@(posedge clock) disable iff (reset)
      widx_ff <= WB'(fcrd_pkg::WORD_BUFFER_BYTES))
      else $error("headword index beyond buffer");

   // length bytes never exceed the four-byte form
   assert property (@(posedge clock) disable iff (reset)
      seen_ff <= fcrd_pkg::LEN_BYTES_LONG)
      else $error("length byte count overran");

   // a byte that is held in the input register waits for a free bundle slot
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !bundle_free) |=> in_valid_ff && $stable(in_byte_ff))
      else $error("stalled input byte lost");

endmodule

// File: design/fcrd_out.sv
// Result bundle register and serializer: hands out one result per
// transaction and marks the last one of each byte. Depends on fcrd_pkg, fcrd_rsp_if.
module fcrd_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  bundle_load,
   input  fcrd_pkg::bundle_type  bundle,
   output logic                  bundle_free,
   fcrd_rsp_if.source            rsp_bus
);

   fcrd_pkg::bundle_type              bundle_ff;
   logic                              valid_ff, valid_in;
   logic [fcrd_pkg::SLOT_BITS-1:0]    slot_ff, slot_in;
   logic                              at_last;
   logic                              taken;
   fcrd_pkg::result_type              cur;

   assign cur     = bundle_ff.res[slot_ff];
   assign at_last = (fcrd_pkg::COUNT_BITS'(slot_ff) + 1'b1) == bundle_ff.count;
   assign taken   = valid_ff && rsp_bus.ready;

   assign bundle_free = !valid_ff || (taken && at_last);

   assign rsp_bus.valid    = valid_ff;
   assign rsp_bus.kind     = cur.kind;
   assign rsp_bus.value    = cur.value;
   assign rsp_bus.position = cur.position;
   assign rsp_bus.last     = at_last;

   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      if (bundle_free) begin
         valid_in = bundle_load;
         slot_in  = '0;
      end else if (taken) begin
         slot_in = slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (bundle_free && bundle_load) begin
         bundle_ff <= bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
      end
   end

   // a held bundle always has at least one result and the slot stays inside it
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (bundle_ff.count != '0 &&
                    fcrd_pkg::COUNT_BITS'(slot_ff) < bundle_ff.count))
      else $error("result slot outside bundle");

   // a result taken short of the last one advances the slot
   assert property (@(posedge clock) disable iff (reset)
      (taken && !at_last) |=> valid_ff && slot_ff == $past(slot_ff) + 1'b1)
      else $error("slot did not advance");

   // a new bundle is only loaded when the old one is fully drained
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_bus.ready) |=> valid_ff && $stable(slot_ff))
      else $error("bundle replaced while stalled");

endmodule

// File: design/front_coded_record_deframer_core.sv
// Top level of the front-coded record deframer: CSR block, parser, result serializer.
// Depends on fcrd_pkg, fcrd_req_if, fcrd_rsp_if, fcrd_csr, fcrd_parser, fcrd_out.
//
//   channel   direction  handshake            payload
//   req_bus   in         valid/ready          data_byte[7:0], block_start
//   rsp_bus   out        valid/ready          kind[2:0], value[7:0], position[23:0], last
//   csr_*     in/out     psel/penable/pready  paddr[2:0], pwdata/prdata[31:0]
//
// Rate: one byte per cycle while the result register is free; a byte that yields results
//   (up to 3) holds the result register until its last result is taken, so the rate is set by the serializer.
// Path: an accepted byte passes the input register and the bundle register before its first result is on rsp_bus.
// Reset: synchronous, active high; clears phase, counters and valid flags,
//   block_size returns to 1024 and aligned_layout to 0.
// Stalls: a stalled rsp_bus holds its bundle; the input register holds one
//   more byte, then req_bus.ready drops.
module front_coded_record_deframer_core (
   input  logic                               clock,
   input  logic                               reset,
   fcrd_req_if.sink                           req_bus,
   fcrd_rsp_if.source                         rsp_bus,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [fcrd_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [fcrd_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [fcrd_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   fcrd_pkg::cfg_type     cfg;
   fcrd_pkg::bundle_type  bundle;
   logic                  bundle_load;
   logic                  bundle_free;

   // configuration registers, read live by the parser
   fcrd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // register the byte, advance the phase, build the result bundle
   fcrd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .cfg         (cfg),
      .bundle_free (bundle_free),
      .bundle_load (bundle_load),
      .bundle      (bundle)
   );

   // hold the bundle and drain it one transaction at a time
   fcrd_out u_out (
      .clock       (clock),
      .reset       (reset),
      .bundle_load (bundle_load),
      .bundle      (bundle),
      .bundle_free (bundle_free),
      .rsp_bus     (rsp_bus)
   );

endmodule
